FILE: hw/rtl/sbls_pkg.sv
package sbls_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_COLLIDERS_DEF = 64;
	localparam int COORD_BITS_DEF    = 20;

	// Fixed field and register widths.
	localparam int COUNT_W    = 7;
	localparam int THICK_W    = 10;
	localparam int INDEX_W    = 6;
	localparam int REG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd0;
	localparam logic [THICK_W-1:0] THICK_RESET = 10'd26;

	// Operation codes of a request.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_COLLIDER_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_THICKNESS  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic wr_commit;
		logic q_init;
		logic q_issue;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic issue_done;
		logic pipe_busy;
		logic out_full;
	} sts_t;

endpackage

FILE: hw/rtl/sbls_if.sv
interface sbls_item_if #(
	parameter int COORD_BITS = sbls_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic [sbls_pkg::INDEX_W-1:0]      entry_index;
	logic signed [COORD_BITS-1:0]      rect_x0;
	logic signed [COORD_BITS-1:0]      rect_z0;
	logic signed [COORD_BITS-1:0]      rect_x1;
	logic signed [COORD_BITS-1:0]      rect_z1;
	logic signed [COORD_BITS-1:0]      seg_ax;
	logic signed [COORD_BITS-1:0]      seg_az;
	logic signed [COORD_BITS-1:0]      seg_bx;
	logic signed [COORD_BITS-1:0]      seg_bz;

	modport source (
		output valid, op, entry_index, rect_x0, rect_z0, rect_x1, rect_z1,
		       seg_ax, seg_az, seg_bx, seg_bz,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, rect_x0, rect_z0, rect_x1, rect_z1,
		       seg_ax, seg_az, seg_bx, seg_bz,
		output ready
	);
endinterface

interface sbls_result_if;
	logic valid;
	logic ready;
	logic line_clear;

	modport source (output valid, line_clear, input ready);
	modport sink (input valid, line_clear, output ready);
endinterface

FILE: hw/rtl/sbls_ram.sv
module sbls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/sbls_ctl.sv
module sbls_ctl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sbls_pkg::sts_t sts,
	output sbls_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DISP = 4'b0010,
		S_RUN  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_query) begin
					cmd.q_init = 1'b1;
					state_d    = S_RUN;
				end else begin
					cmd.wr_commit = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RUN: begin
				cmd.q_issue = !sts.issue_done;
				if (sts.issue_done && !sts.pipe_busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	// A table write follows directly on the request that carried it.
	a_wr_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_commit |-> $past(cmd.load))
		else $error("table write without a preceding request");
`endif

endmodule

FILE: hw/rtl/sbls_dp.sv
module sbls_dp #(
	parameter int MAX_COLLIDERS = sbls_pkg::MAX_COLLIDERS_DEF,
	parameter int COORD_BITS    = sbls_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbls_pkg::cmd_t                      cmd,
	output sbls_pkg::sts_t                      sts,
	input  logic                                wr_en,
	input  logic [sbls_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [sbls_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                op,
	input  logic [sbls_pkg::INDEX_W-1:0]        entry_index,
	input  logic signed [COORD_BITS-1:0]        rect_x0,
	input  logic signed [COORD_BITS-1:0]        rect_z0,
	input  logic signed [COORD_BITS-1:0]        rect_x1,
	input  logic signed [COORD_BITS-1:0]        rect_z1,
	input  logic signed [COORD_BITS-1:0]        seg_ax,
	input  logic signed [COORD_BITS-1:0]        seg_az,
	input  logic signed [COORD_BITS-1:0]        seg_bx,
	input  logic signed [COORD_BITS-1:0]        seg_bz,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                line_clear
);

	localparam int CB    = COORD_BITS;
	localparam int NW    = CB + 2;
	localparam int PW    = 2 * NW;
	localparam int RW    = 4 * CB;
	localparam int AW    = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
	localparam int CNT_W = $clog2(MAX_COLLIDERS + 1);
	localparam int LIM_W = (CNT_W > sbls_pkg::COUNT_W) ? CNT_W : sbls_pkg::COUNT_W;
	localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_COLLIDERS);
	localparam logic signed [NW-1:0] CMAX = NW'((64'sd1 <<< (CB - 1)) - 64'sd1);
	localparam logic signed [NW-1:0] CMIN = -CMAX - NW'(1);

	typedef struct packed {
		logic          act;
		logic          sep;
		logic [NW-1:0] en;
		logic [NW-1:0] xn;
		logic [NW-1:0] dd;
	} axis_t;

	// Orders two corners, widens a thin axis about its midpoint and saturates.
	// The low bound sits in the upper half of the result.
	function automatic logic [2*CB-1:0] make_axis(
		input logic signed [CB-1:0] c0,
		input logic signed [CB-1:0] c1,
		input logic [sbls_pkg::THICK_W-1:0] t
	);
		logic signed [NW-1:0] lo, hi, s, tw;
		tw = $signed(NW'(t));
		lo = (c0 < c1) ? NW'(c0) : NW'(c1);
		hi = (c0 < c1) ? NW'(c1) : NW'(c0);
		if (hi - lo < tw) begin
			s  = NW'(c0) + NW'(c1) - tw;
			lo = s >>> 1;
			hi = lo + tw;
		end
		lo = (lo < CMIN) ? CMIN : ((lo > CMAX) ? CMAX : lo);
		hi = (hi < CMIN) ? CMIN : ((hi > CMAX) ? CMAX : hi);
		return {lo[CB-1:0], hi[CB-1:0]};
	endfunction

	// Slab of one axis: entry and exit numerators over a positive delta.
	function automatic axis_t prep(
		input logic signed [CB-1:0] a,
		input logic signed [CB:0]   d,
		input logic signed [CB-1:0] lo,
		input logic signed [CB-1:0] hi
	);
		axis_t r;
		logic signed [NW-1:0] n0, n1, dd;
		n0 = NW'(lo) - NW'(a);
		n1 = NW'(hi) - NW'(a);
		dd = NW'(d);
		if (d < 0) begin
			n0 = -n0;
			n1 = -n1;
			dd = -dd;
		end
		r.act = (d != 0);
		r.sep = (d == 0) && ((a < lo) || (a > hi));
		r.en  = (n0 < n1) ? n0 : n1;
		r.xn  = (n0 < n1) ? n1 : n0;
		r.dd  = dd;
		return r;
	endfunction

	logic [sbls_pkg::COUNT_W-1:0] collider_count_q;
	logic [sbls_pkg::THICK_W-1:0] min_thickness_q;

	logic                         op_q;
	logic [sbls_pkg::INDEX_W-1:0] idx_q;
	logic signed [CB-1:0]         rx0_q, rz0_q, rx1_q, rz1_q;
	logic signed [CB-1:0]         ax_q, az_q;
	logic signed [CB:0]           dx_q, dz_q;

	logic [LIM_W-1:0] cnt_q, n_lim, idx_ext;
	logic             hit_q, v_rd_q, v_s1_q, v_s2_q;
	logic             out_valid_q, line_clear_q;

	logic             ram_we;
	logic [RW-1:0]    ram_wdata, ram_rdata;

	axis_t            ax_s1, az_s1;
	logic signed [PW-1:0] p12_s2, q12_s2, p21_s2, q21_s2;
	logic             simple_s2, both_s2;
	logic             ok_x, ok_z, box_hit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collider_count_q <= sbls_pkg::COUNT_RESET;
			min_thickness_q  <= sbls_pkg::THICK_RESET;
		end else if (wr_en) begin
			case (wr_index)
				sbls_pkg::REG_COLLIDER_COUNT:
					collider_count_q <= wr_data[sbls_pkg::COUNT_W-1:0];
				sbls_pkg::REG_MIN_THICKNESS:
					min_thickness_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			idx_q <= entry_index;
			rx0_q <= rect_x0;
			rz0_q <= rect_z0;
			rx1_q <= rect_x1;
			rz1_q <= rect_z1;
			ax_q  <= seg_ax;
			az_q  <= seg_az;
			dx_q  <= (CB+1)'(seg_bx) - (CB+1)'(seg_ax);
			dz_q  <= (CB+1)'(seg_bz) - (CB+1)'(seg_az);
		end
	end

	assign idx_ext   = LIM_W'(idx_q);
	assign ram_we    = cmd.wr_commit && (idx_ext < MAX_L);
	assign ram_wdata = {make_axis(rx0_q, rx1_q, min_thickness_q),
	                    make_axis(rz0_q, rz1_q, min_thickness_q)};
	assign n_lim     = (LIM_W'(collider_count_q) > MAX_L) ? MAX_L
	                                                      : LIM_W'(collider_count_q);

	sbls_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_COLLIDERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_ext[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(cnt_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Walk control and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hit_q  <= 1'b0;
			v_rd_q <= 1'b0;
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_rd_q <= cmd.q_issue;
			v_s1_q <= v_rd_q;
			v_s2_q <= v_s1_q;
			if (cmd.q_init) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.q_issue) begin
					cnt_q <= cnt_q + LIM_W'(1);
				end
				if (v_s2_q && box_hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Stage 1: slab numerators from the stored bounds.
	always_ff @(posedge clk) begin
		ax_s1 <= prep(ax_q, dx_q, ram_rdata[4*CB-1:3*CB], ram_rdata[3*CB-1:2*CB]);
		az_s1 <= prep(az_q, dz_q, ram_rdata[2*CB-1:CB], ram_rdata[CB-1:0]);
	end

	// Checks against the fixed range [0, 1].
	assign ok_x = !ax_s1.act || (($signed(ax_s1.xn) >= 0) &&
	              ($signed(ax_s1.en) <= $signed(ax_s1.dd)));
	assign ok_z = !az_s1.act || (($signed(az_s1.xn) >= 0) &&
	              ($signed(az_s1.en) <= $signed(az_s1.dd)));

	// Stage 2: cross products for the two mixed-axis comparisons.
	always_ff @(posedge clk) begin
		p12_s2    <= PW'($signed(ax_s1.en)) * PW'($signed(az_s1.dd));
		q12_s2    <= PW'($signed(az_s1.xn)) * PW'($signed(ax_s1.dd));
		p21_s2    <= PW'($signed(az_s1.en)) * PW'($signed(ax_s1.dd));
		q21_s2    <= PW'($signed(ax_s1.xn)) * PW'($signed(az_s1.dd));
		simple_s2 <= !ax_s1.sep && !az_s1.sep && ok_x && ok_z;
		both_s2   <= ax_s1.act && az_s1.act;
	end

	assign box_hit = simple_s2 && (!both_s2 || ((p12_s2 <= q12_s2) && (p21_s2 <= q21_s2)));

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			line_clear_q <= !hit_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_clear = line_clear_q;

	assign sts.is_query   = (op_q == sbls_pkg::OP_QUERY);
	assign sts.issue_done = (cnt_q >= n_lim);
	assign sts.pipe_busy  = v_rd_q || v_s1_q || v_s2_q;
	assign sts.out_full   = out_valid_q && !out_ready;

`ifndef SYNTH
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_issue |-> (cnt_q < n_lim))
		else $error("table read beyond the tested entries");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result loaded over one not yet taken");
	a_empty_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (n_lim == '0)) |-> !hit_q)
		else $error("blocked result with no boxes tested");
`endif

endmodule

FILE: hw/rtl/segment_box_line_of_sight.sv
// Line-of-sight test of a 2D segment against a table of axis-aligned boxes.
// A request with op 0 stores a box at entry_index: its corners are put in
// order, an axis thinner than min_thickness is widened about its midpoint,
// and the bounds are clamped to the coordinate range. A write gives no
// result. A request with op 1 carries a segment from (seg_ax, seg_az) to
// (seg_bx, seg_bz) and returns one result, line_clear, which is 1 when
// none of the first collider_count boxes is crossed. The slab test is
// exact: parameters are compared by cross-multiplication. A query tests
// at most MAX_COLLIDERS boxes, one at a time, as the box table has one
// read port: one box is read per cycle and passes through a three-stage
// compare pipeline. A new request is accepted while a result still waits
// to be taken. Table entries that were never written read back undefined,
// so a query must only cover written entries. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module segment_box_line_of_sight #(
	parameter int MAX_COLLIDERS = sbls_pkg::MAX_COLLIDERS_DEF,
	parameter int COORD_BITS    = sbls_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sbls_item_if.sink                       item,
	sbls_result_if.source                   result,
	input  logic                            wr_en,
	input  logic [sbls_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [sbls_pkg::CFG_DATA_W-1:0] wr_data
);

	sbls_pkg::cmd_t cmd;
	sbls_pkg::sts_t sts;

	// The controller sequences write commit, table walk and result load.
	sbls_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_ready(item.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds the registers, the box table and the compare pipeline.
	sbls_dp #(
		.MAX_COLLIDERS(MAX_COLLIDERS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.op         (item.op),
		.entry_index(item.entry_index),
		.rect_x0    (item.rect_x0),
		.rect_z0    (item.rect_z0),
		.rect_x1    (item.rect_x1),
		.rect_z1    (item.rect_z1),
		.seg_ax     (item.seg_ax),
		.seg_az     (item.seg_az),
		.seg_bx     (item.seg_bx),
		.seg_bz     (item.seg_bz),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.line_clear (result.line_clear)
	);

endmodule
